// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the member picker; they compile away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LLMP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("llmp assertion failed");
`define LLMP_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("llmp forbidden condition seen");
`else
`define LLMP_ASSERT(lbl, clk, rst, prop)
`define LLMP_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- rtl/llmp_pkg.sv -----
// ----------------------------------------------------------------------------
// llmp_pkg
// Shared types and codes of the least-loaded member picker.
// ----------------------------------------------------------------------------
package llmp_pkg;

   localparam int LOAD_W    = 16;  // width of the reported load
   localparam int IDX_OUT_W = 4;   // width of member indexes on the ports
   localparam int MASK_W    = 16;  // members that own mask bits
   localparam int MCOUNT_W  = 5;   // member count register
   localparam int CSR_W     = 16;  // configuration write data

   typedef enum logic [1:0] {
      CSR_MEMBER_COUNT = 2'd0,
      CSR_BLOCKED_MASK = 2'd1,
      CSR_USABLE_MASK  = 2'd2,
      CSR_SINGLE_REG   = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_GRANTED = 3'd0,
      ST_SINGLE  = 3'd1,
      ST_NONE    = 3'd2,
      ST_PUT_OK  = 3'd3,
      ST_PUT_REJ = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE   = 3'd0,
      FSM_SCAN   = 3'd1,
      FSM_PREAD  = 3'd2,
      FSM_PLOAD  = 3'd3,
      FSM_UPDATE = 3'd4
   } fsm_type;

   typedef enum logic [1:0] {
      OP_CMP = 2'd0,
      OP_INC = 2'd1,
      OP_DEC = 2'd2
   } step_op_type;

   typedef struct packed {
      kind_type               kind;
      logic [IDX_OUT_W-1:0]   member_index;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [IDX_OUT_W-1:0]   granted_index;
      logic [LOAD_W-1:0]      member_load;
      logic                   count_underflow;
   } rsp_type;

endpackage

// ----- rtl/llmp_count_mem.sv -----
// ----------------------------------------------------------------------------
// llmp_count_mem
// Use count store: one write port, one registered read port. Per-entry
// valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
module llmp_count_mem
   import llmp_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic             valid_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= valid_ff[rd_addr];
         end
      end
   end

   // unwritten entries read as zero through their cleared valid bit
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/llmp_step_unit.sv -----
// ----------------------------------------------------------------------------
// llmp_step_unit
// Shared adder: compares two counts during the scan, then increments
// (saturating) or decrements the chosen count.
// ----------------------------------------------------------------------------
module llmp_step_unit
   import llmp_pkg::*;
#(
   parameter int WIDTH = 16
) (
   input  step_op_type      op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] y,
   output logic             less
);

   logic [WIDTH-1:0] b_x;
   logic [WIDTH:0]   sum;

   always_comb begin
      case (op)
         OP_CMP:  b_x = ~b;
         OP_INC:  b_x = '0;
         OP_DEC:  b_x = ~WIDTH'(1);
         default: b_x = '0;
      endcase
      // carry in is always one: a - b, a + 1 or a - 1
      sum  = {1'b0, a} + {1'b0, b_x} + (WIDTH+1)'(1);
      less = (op == OP_CMP) && !sum[WIDTH];
      y    = ((op == OP_INC) && sum[WIDTH]) ? '1 : sum[WIDTH-1:0];
   end

endmodule

// ----- rtl/least_loaded_member_picker.sv -----
// ----------------------------------------------------------------------------
// least_loaded_member_picker
// Least-connections member selection with per-member use counts.
// ----------------------------------------------------------------------------
// Usage: a req word asks for a member (get) or hands one back (put); each
// req word yields exactly one rsp word. csr words set the member count,
// blocked and usable masks and the single fallback flag; csr_ready is always
// high and writes belong to idle periods only.
// A get walks the configured members through one count memory read port, one
// member per cycle, and a single shared adder compares each count with the
// best so far, then bumps the winner in the update step, where the rsp
// word is also registered. A put to a pool member reads its count first,
// and a get on an empty pool or a put outside the pool goes straight to
// the update step. One word is in flight at a time.
// Reset clears the configuration, sequencer and scan registers and the
// count valid bits at once, so every count reads zero; no sweep is needed.
// When the receiver stalls, the rsp word holds in its output register and
// the sequencer waits in its update step before writing the counts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module least_loaded_member_picker
   import llmp_pkg::*;
#(
   parameter int MAX_MEMBERS = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  csr_index_type        csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

   // configuration registers
   logic [MCOUNT_W-1:0]    member_count_ff;
   logic [MASK_W-1:0]      blocked_ff;
   logic [MASK_W-1:0]      usable_ff;
   logic                   single_ff;

   // sequencer and scan state
   fsm_type                state_ff, state_in;
   req_type                req_ff;
   logic [MCOUNT_W-1:0]    scan_ff;
   logic                   look_ff;
   logic [MCOUNT_W-1:0]    look_idx_ff;
   logic                   found_ff;
   logic [MCOUNT_W-1:0]    best_ff;
   logic [COUNT_WIDTH-1:0] best_cnt_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   // datapath nets
   logic [MCOUNT_W-1:0]    n_eff;
   logic                   req_in_pool;
   logic                   look_elig;
   logic                   rsp_free;
   logic                   req_take;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [COUNT_WIDTH-1:0] mem_rd_data;
   logic                   mem_wr_en;
   step_op_type            step_op;
   logic [COUNT_WIDTH-1:0] step_a;
   logic [COUNT_WIDTH-1:0] step_y;
   logic                   step_less;
   logic                   rsp_load;
   rsp_type                rsp_new;

   // counts above the pool size act as the pool size
   assign n_eff = (32'(member_count_ff) > 32'(MAX_MEMBERS)) ?
                  MCOUNT_W'(MAX_MEMBERS) : member_count_ff;

   assign req_in_pool = ({1'b0, req_data.member_index} < n_eff) &&
                        usable_ff[req_data.member_index];

   // only members with mask bits can ever be picked
   assign look_elig = (look_idx_ff < MCOUNT_W'(MASK_W)) &&
                      !blocked_ff[look_idx_ff[IDX_OUT_W-1:0]] &&
                      usable_ff[look_idx_ff[IDX_OUT_W-1:0]];

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         member_count_ff <= '0;
         blocked_ff      <= '0;
         usable_ff       <= '0;
         single_ff       <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MEMBER_COUNT: member_count_ff <= csr_data[MCOUNT_W-1:0];
            CSR_BLOCKED_MASK: blocked_ff      <= csr_data[MASK_W-1:0];
            CSR_USABLE_MASK:  usable_ff       <= csr_data[MASK_W-1:0];
            CSR_SINGLE_REG:   single_ff       <= csr_data[0];
            default:          single_ff       <= single_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_take) begin
               if (req_data.kind == KIND_GET) begin
                  state_in = (n_eff == '0) ? FSM_UPDATE : FSM_SCAN;
               end else begin
                  state_in = req_in_pool ? FSM_PREAD : FSM_UPDATE;
               end
            end
         end
         FSM_SCAN: begin
            // all reads issued and the last one judged
            if ((scan_ff >= n_eff) && !look_ff) begin
               state_in = FSM_UPDATE;
            end
         end
         FSM_PREAD:  state_in = FSM_PLOAD;
         FSM_PLOAD:  state_in = FSM_UPDATE;
         FSM_UPDATE: begin
            if (rsp_free) begin
               state_in = FSM_IDLE;
            end
         end
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------
   // sequencer: outputs to memory, shared adder and response register
   // ------------------------------------------------------------------
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = IDX_W'(scan_ff);
      mem_wr_en   = 1'b0;
      step_op     = OP_CMP;
      step_a      = mem_rd_data;
      rsp_load    = 1'b0;
      rsp_new     = '{status: ST_NONE, granted_index: '0, member_load: '0,
                      count_underflow: 1'b0};
      unique case (state_ff)
         FSM_SCAN: begin
            mem_rd_en = (scan_ff < n_eff);
         end
         FSM_PREAD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = IDX_W'(best_ff);
         end
         FSM_UPDATE: begin
            step_a   = best_cnt_ff;
            step_op  = (req_ff.kind == KIND_GET) ? OP_INC : OP_DEC;
            rsp_load = rsp_free;
            if (req_ff.kind == KIND_GET) begin
               if (n_eff == '0) begin
                  rsp_new.status = single_ff ? ST_SINGLE : ST_NONE;
               end else if (found_ff) begin
                  mem_wr_en             = rsp_free;
                  rsp_new.status        = ST_GRANTED;
                  rsp_new.granted_index = best_ff[IDX_OUT_W-1:0];
                  rsp_new.member_load   = LOAD_W'(step_y);
               end
            end else begin
               rsp_new.granted_index = req_ff.member_index;
               if (!found_ff) begin
                  rsp_new.status = ST_PUT_REJ;
               end else if (best_cnt_ff == '0) begin
                  rsp_new.status          = ST_PUT_REJ;
                  rsp_new.count_underflow = 1'b1;
               end else begin
                  mem_wr_en           = rsp_free;
                  rsp_new.status      = ST_PUT_OK;
                  rsp_new.member_load = LOAD_W'(step_y);
               end
            end
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // scan datapath
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff      <= '0;
         scan_ff     <= '0;
         look_ff     <= 1'b0;
         look_idx_ff <= '0;
         found_ff    <= 1'b0;
         best_ff     <= '0;
         best_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            FSM_IDLE: begin
               if (req_take) begin
                  req_ff      <= req_data;
                  scan_ff     <= '0;
                  look_ff     <= 1'b0;
                  best_cnt_ff <= '0;
                  // a put marks its member found only when it is in the pool
                  found_ff    <= (req_data.kind == KIND_PUT) && req_in_pool;
                  best_ff     <= (req_data.kind == KIND_PUT) ?
                                 {1'b0, req_data.member_index} : '0;
               end
            end
            FSM_SCAN: begin
               // judge the word read last cycle; ties keep the lower index
               if (look_ff && look_elig && (!found_ff || step_less)) begin
                  best_ff     <= look_idx_ff;
                  best_cnt_ff <= mem_rd_data;
                  found_ff    <= 1'b1;
               end
               look_ff     <= mem_rd_en;
               look_idx_ff <= scan_ff;
               if (mem_rd_en) begin
                  scan_ff <= scan_ff + MCOUNT_W'(1);
               end
            end
            FSM_PLOAD: begin
               best_cnt_ff <= mem_rd_data;
            end
            default: begin
               look_ff <= 1'b0;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // response register: hold while the receiver stalls
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_new;
      end
   end

   // ------------------------------------------------------------------
   // use count memory and shared adder
   // ------------------------------------------------------------------
   llmp_count_mem #(
      .DEPTH (MAX_MEMBERS),
      .WIDTH (COUNT_WIDTH),
      .AW    (IDX_W)
   ) u_count_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (IDX_W'(best_ff)),
      .wr_data (step_y)
   );

   llmp_step_unit #(
      .WIDTH (COUNT_WIDTH)
   ) u_step_unit (
      .op   (step_op),
      .a    (step_a),
      .b    (best_cnt_ff),
      .y    (step_y),
      .less (step_less)
   );

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `LLMP_ASSERT(a_write_has_mask, clock, reset, mem_wr_en |-> (best_ff < MCOUNT_W'(MASK_W)))
   `LLMP_ASSERT(a_busy_after_accept, clock, reset, req_take |=> !req_ready)
   `LLMP_ASSERT(a_best_behind_scan, clock, reset, (state_ff == FSM_SCAN && found_ff) |-> (best_ff < scan_ff))
   `LLMP_ASSERT(a_rsp_from_update, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == FSM_UPDATE))
   `LLMP_ASSERT_NEVER(a_underflow_rejects, clock, reset, rsp_valid_ff && rsp_ff.count_underflow && (rsp_ff.status != ST_PUT_REJ))

endmodule

// ----- verif/llmp_score_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// llmp_score_pkg
// Load bookkeeping for the member picker bench: mirrors the registers and
// per-member use counts, predicts the rsp word of every accepted req word
// and checks the rsp words against them in order.
// ----------------------------------------------------------------------------
package llmp_score_pkg;
   import llmp_pkg::*;

   localparam int MEMBERS = 16;
   localparam int COUNT_W = 16;
   localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

   class member_load_book;
      logic [COUNT_W-1:0]  use_count [MEMBERS];
      logic [MCOUNT_W-1:0] member_count;
      logic [MASK_W-1:0]   blocked;
      logic [MASK_W-1:0]   usable;
      logic                single_reg;
      rsp_type             expected_q [$];
      int unsigned         failures;

      function new();
         foreach (use_count[i]) use_count[i] = '0;
         member_count = '0;
         blocked      = '0;
         usable       = '0;
         single_reg   = 1'b0;
         failures     = 0;
      endfunction

      function int unsigned live_members();
         return (member_count > MEMBERS) ? MEMBERS : member_count;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void apply_csr(csr_index_type idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_MEMBER_COUNT: member_count = data[MCOUNT_W-1:0];
            CSR_BLOCKED_MASK: blocked      = data[MASK_W-1:0];
            CSR_USABLE_MASK:  usable       = data[MASK_W-1:0];
            CSR_SINGLE_REG:   single_reg   = data[0];
            default: ;
         endcase
      endfunction

      // Random usable member that currently holds load, for well-formed puts.
      function logic [IDX_OUT_W-1:0] loaded_member();
         int unsigned cand [$];
         int unsigned n;
         n = live_members();
         for (int i = 0; i < n; i++)
            if (usable[i] && use_count[i] != '0) cand.push_back(i);
         if (cand.size() == 0) return IDX_OUT_W'($urandom_range(MEMBERS - 1));
         return IDX_OUT_W'(cand[$urandom_range(cand.size() - 1)]);
      endfunction

      function void note_request(req_type r);
         rsp_type     e;
         int unsigned n;
         int unsigned best;
         int unsigned idx;
         bit          found;
         e     = '0;
         n     = live_members();
         best  = 0;
         found = 1'b0;
         if (r.kind == KIND_GET) begin
            if (n == 0) begin
               e.status = single_reg ? ST_SINGLE : ST_NONE;
            end else begin
               for (int i = 0; i < n; i++) begin
                  if (blocked[i] || !usable[i]) continue;
                  if (!found || use_count[i] < use_count[best]) begin
                     best  = i;
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  e.status = ST_NONE;
               end else begin
                  if (use_count[best] != COUNT_TOP) use_count[best] += 1'b1;
                  e.status        = ST_GRANTED;
                  e.granted_index = IDX_OUT_W'(best);
                  e.member_load   = LOAD_W'(use_count[best]);
               end
            end
         end else begin
            idx             = r.member_index;
            e.granted_index = r.member_index;
            if (idx >= n || !usable[idx]) begin
               e.status = ST_PUT_REJ;
            end else if (use_count[idx] == '0) begin
               e.status          = ST_PUT_REJ;
               e.count_underflow = 1'b1;
            end else begin
               use_count[idx] -= 1'b1;
               e.status      = ST_PUT_OK;
               e.member_load = LOAD_W'(use_count[idx]);
            end
         end
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected rsp word: status %0d index %0d load %0d uf %0d",
                        got.status, got.granted_index, got.member_load,
                        got.count_underflow);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status || got.granted_index !== want.granted_index ||
             got.member_load !== want.member_load ||
             got.count_underflow !== want.count_underflow) begin
            failures++;
            if (failures <= 10)
               $display("rsp mismatch: want status %0d index %0d load %0d uf %0d, got status %0d index %0d load %0d uf %0d",
                        want.status, want.granted_index, want.member_load,
                        want.count_underflow, got.status, got.granted_index,
                        got.member_load, got.count_underflow);
         end
      endfunction
   endclass

endpackage

// ----- verif/tb_least_loaded_member_picker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_least_loaded_member_picker
// Drives get and put words into the member picker under several register
// settings, with random gaps and back-pressure, and checks every rsp word
// against a running model of the per-member use counts. Ends with a short
// run of gets and puts on a single member.
// ----------------------------------------------------------------------------
module tb_least_loaded_member_picker;
   import llmp_pkg::*;
   import llmp_score_pkg::*;

   localparam int DRAIN_CYCLES = 24;   // longer than a full scan at sixteen members
   localparam int TAIL_CYCLES  = 30;
   localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
   localparam int PHASE_WORDS  = 125;
   localparam int PHASES       = 10;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   csr_index_type       csr_index;
   logic [CSR_W-1:0]    csr_data;

   // shared knobs: idling on or off, and a request for a long rsp hold-off
   bit                  idle_on;
   logic                hold_kick;
   int unsigned         hold_left;

   member_load_book     book;

   least_loaded_member_picker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Hard stop in case a handshake never completes.
   initial begin
      #30ms;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: check the rsp word taken at this edge, then pick ready for
   // the next one. A hold-off request drops ready while the HOLD_CYCLES countdown runs.
   initial begin
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) book.check_response(rsp_data);
         if (hold_kick) begin
            hold_left = HOLD_CYCLES;
            hold_kick <= 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= idle_on ? ($urandom_range(99) >= 38) : 1'b1;
         end
      end
   end

   function automatic req_type make_req(kind_type k, logic [IDX_OUT_W-1:0] idx);
      req_type r;
      r.kind         = k;
      r.member_index = idx;
      return r;
   endfunction

   // Mostly well-formed traffic: gets, and puts of members that hold load;
   // the rest is noise with any kind and any index.
   function automatic req_type random_req();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55) return make_req(KIND_GET, IDX_OUT_W'($urandom));
      if (roll < 85) return make_req(KIND_PUT, book.loaded_member());
      return make_req(kind_type'($urandom_range(1)), IDX_OUT_W'($urandom));
   endfunction

   // Offer one req word and hold it until taken; a gap, if any, comes first
   // so valid is never lowered and raised in the same step.
   task automatic send_req(input req_type r);
      if (idle_on && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_on && $urandom_range(99) < 38);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      book.note_request(r);
   endtask

   task automatic csr_word(input csr_index_type idx, input logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      book.apply_csr(idx, data);
   endtask

   // Drain the block, then write all four registers back to back. Unused
   // upper data bits carry noise; the block must drop them.
   task automatic write_config(input logic [MCOUNT_W-1:0] mc, input logic [MASK_W-1:0] bm,
                               input logic [MASK_W-1:0] um, input logic sr);
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_word(CSR_MEMBER_COUNT, {(CSR_W-MCOUNT_W)'($urandom), mc});
      csr_word(CSR_BLOCKED_MASK, bm);
      csr_word(CSR_USABLE_MASK, um);
      csr_word(CSR_SINGLE_REG, {(CSR_W-1)'($urandom), sr});
      csr_valid <= 1'b0;
   endtask

   task automatic random_config(input int phase);
      logic [MCOUNT_W-1:0] mc;
      logic [MASK_W-1:0]   bm;
      logic [MASK_W-1:0]   um;
      int unsigned         roll;
      roll = $urandom_range(99);
      if (roll < 10)      mc = '0;
      else if (roll < 22) mc = MCOUNT_W'(MEMBERS);
      else if (roll < 32) mc = MCOUNT_W'($urandom_range(31, MEMBERS + 1));
      else                mc = MCOUNT_W'($urandom_range(MEMBERS - 1, 1));
      roll = $urandom_range(99);
      if (roll < 15)      bm = '0;
      else if (roll < 25) bm = '1;
      else if (roll < 85) bm = MASK_W'($urandom & $urandom & $urandom);
      else                bm = MASK_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 15)      um = '1;
      else if (roll < 25) um = '0;
      else if (roll < 85) um = MASK_W'($urandom | $urandom);
      else                um = MASK_W'($urandom);
      // pin the first phases to the extremes of the pool size
      if (phase == 0) begin
         mc = MCOUNT_W'(MEMBERS);
         bm = '0;
         um = '1;
      end else if (phase == 1) begin
         mc = MCOUNT_W'(1);
         um = '1;
      end
      write_config(mc, bm, um, 1'($urandom));
   endtask

   initial begin
      book      = new();
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_MEMBER_COUNT;
      csr_data  = '0;
      hold_kick = 1'b0;
      idle_on   = 1'b1;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: registers at reset, empty pool without fallback.
      send_req(make_req(KIND_GET, 4'd0));
      send_req(make_req(KIND_PUT, 4'd0));

      // Empty pool with the single fallback client.
      write_config(5'd0, 16'h0000, 16'hFFFF, 1'b1);
      send_req(make_req(KIND_GET, 4'd9));
      send_req(make_req(KIND_PUT, 4'd15));

      // Four members: fill evenly, then a tie goes to the lowest index.
      write_config(5'd4, 16'h0000, 16'h000F, 1'b0);
      repeat (5) send_req(make_req(KIND_GET, 4'd0));
      // Hand member 0 back down past zero, then a put outside the pool.
      repeat (3) send_req(make_req(KIND_PUT, 4'd0));
      send_req(make_req(KIND_PUT, 4'd4));

      // Count above the pool size: only member 15 is left unblocked.
      write_config(5'd31, 16'h7FFF, 16'hFFFF, 1'b0);
      send_req(make_req(KIND_GET, 4'd0));
      send_req(make_req(KIND_PUT, 4'd15));
      send_req(make_req(KIND_GET, 4'd0));
      // Put to a blocked member still goes through.
      send_req(make_req(KIND_PUT, 4'd3));

      // Full pool, everything blocked: none available.
      write_config(5'd16, 16'hFFFF, 16'hFFFF, 1'b1);
      send_req(make_req(KIND_GET, 4'd0));

      // Nothing usable: gets find nobody, puts are rejected.
      write_config(5'd16, 16'h0000, 16'h0000, 1'b1);
      send_req(make_req(KIND_GET, 4'd0));
      send_req(make_req(KIND_PUT, 4'd5));

      // Random phases; one runs with no idling, one starts with a long
      // receiver hold-off while the sender keeps offering.
      for (int p = 0; p < PHASES; p++) begin
         random_config(p);
         idle_on = (p != 4);
         if (p == 2) hold_kick <= 1'b1;
         repeat (PHASE_WORDS) send_req(random_req());
      end

      // One member: a burst of gets, then walk it back down a little.
      write_config(5'd1, 16'h0000, 16'h0001, 1'b0);
      idle_on = 1'b0;
      repeat (8) send_req(make_req(KIND_GET, IDX_OUT_W'($urandom)));
      idle_on = 1'b1;
      repeat (3) send_req(make_req(KIND_PUT, 4'd0));
      send_req(make_req(KIND_GET, 4'd0));

      // Wait out the last rsp words, then a quiet tail.
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
